// ===== hw/rtl/prefix_varint_decoder_assert.svh =====
`ifndef PREFIX_VARINT_DECODER_ASSERT_SVH
`define PREFIX_VARINT_DECODER_ASSERT_SVH

// Same-cycle implication, checked only while out of reset.
`define PVD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prefix_varint_decoder: same-cycle check failed");

// Next-cycle implication, checked only while out of reset.
`define PVD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prefix_varint_decoder: next-cycle check failed");

`endif

// ===== hw/rtl/pvd_pkg.sv =====
`default_nettype none

package pvd_pkg;

  localparam logic [7:0] ESCAPE_MARKER     = 8'hFF;
  localparam logic [3:0] ESCAPE_LEN        = 4'd9;
  localparam int         MAX_TRAILING_ONES = 7;

  typedef struct packed {
    logic [63:0] raw;
    logic [3:0]  len;
    logic        esc;
    logic        trunc;
  } rec_t;

  function automatic logic [3:0] first_len(input logic [7:0] b);
    logic [3:0] n;
    logic       run;
    n   = 4'd1;
    run = 1'b1;
    for (int i = 0; i < MAX_TRAILING_ONES; i++) begin
      run = run & b[i];
      if (run) begin
        n = n + 4'd1;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pvd_front.sv =====
`default_nettype none

module pvd_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_buffer,
  input  wire logic        q_full,
  output logic             q_push,
  output pvd_pkg::rec_t    q_push_data,
  output logic             front_idle
);

  logic [3:0]  exp_r, exp_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic        esc_r, esc_nxt;
  logic [63:0] acc_r, acc_nxt;

  logic        accept;
  logic [3:0]  exp_a, pos_a, slot;
  logic        esc_a;
  logic [63:0] acc_a;
  logic        done;

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign front_idle = (exp_r == 4'd0);

  always_comb begin
    slot = esc_r ? (pos_r - 4'd1) : pos_r;
    if (exp_r == 4'd0) begin
      pos_a = 4'd1;
      if (in_data_byte == pvd_pkg::ESCAPE_MARKER) begin
        esc_a = 1'b1;
        exp_a = pvd_pkg::ESCAPE_LEN;
        acc_a = 64'd0;
      end else begin
        esc_a = 1'b0;
        exp_a = pvd_pkg::first_len(in_data_byte);
        acc_a = {56'd0, in_data_byte};
      end
    end else begin
      esc_a = esc_r;
      exp_a = exp_r;
      pos_a = pos_r + 4'd1;
      acc_a = acc_r | ({56'd0, in_data_byte} << {slot[2:0], 3'b000});
    end
    done = (pos_a >= exp_a);

    exp_nxt     = exp_r;
    pos_nxt     = pos_r;
    esc_nxt     = esc_r;
    acc_nxt     = acc_r;
    q_push      = 1'b0;
    q_push_data = '{raw: acc_a, len: exp_a, esc: esc_a, trunc: 1'b0};

    if (accept) begin
      if (done || in_end_of_buffer) begin
        q_push  = 1'b1;
        exp_nxt = 4'd0;
        pos_nxt = 4'd0;
        esc_nxt = 1'b0;
        acc_nxt = 64'd0;
        if (!done) begin
          q_push_data = '{raw: 64'd0, len: 4'd0, esc: 1'b0, trunc: 1'b1};
        end
      end else begin
        exp_nxt = exp_a;
        pos_nxt = pos_a;
        esc_nxt = esc_a;
        acc_nxt = acc_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= 4'd0;
      pos_r <= 4'd0;
      esc_r <= 1'b0;
      acc_r <= 64'd0;
    end else begin
      exp_r <= exp_nxt;
      pos_r <= pos_nxt;
      esc_r <= esc_nxt;
      acc_r <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pvd_fifo.sv =====
`default_nettype none

module pvd_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  pvd_pkg::rec_t      push_data,
  output logic               full,
  input  wire logic          pop,
  output pvd_pkg::rec_t      pop_data,
  output logic               empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  pvd_pkg::rec_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full     = (count_r == FULL_COUNT);
  assign empty    = (count_r == '0);
  assign count    = count_r;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pvd_back.sv =====
`default_nettype none

module pvd_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_empty,
  input  pvd_pkg::rec_t     q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [63:0]       out_decoded_value,
  output logic [3:0]        out_field_length,
  output logic              out_truncated
);

  logic        out_valid_r, out_valid_nxt;
  logic [63:0] value_r;
  logic [3:0]  len_r;
  logic        trunc_r;
  logic [63:0] value_c;

  assign q_pop = !q_empty && (!out_valid_r || out_ready);

  always_comb begin
    if (q_data.trunc) begin
      value_c = 64'd0;
    end else if (q_data.esc) begin
      value_c = q_data.raw;
    end else begin
      value_c = q_data.raw >> q_data.len;
    end
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      value_r <= value_c;
      len_r   <= q_data.trunc ? 4'd0 : q_data.len;
      trunc_r <= q_data.trunc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_decoded_value = value_r;
  assign out_field_length  = len_r;
  assign out_truncated     = trunc_r;

endmodule

`default_nettype wire

// ===== hw/rtl/prefix_varint_decoder.sv =====
// Prefix varint decoder: one encoded byte per transfer on the in_ channel,
// with in_end_of_buffer marking the last byte of a buffer. Each completed
// field produces one transfer on the out_ channel carrying the value and
// the field length of 1 to 9 bytes. A buffer that ends inside a field
// produces one result with out_truncated set and zero value and length.
// Bytes in the middle of a field produce nothing.
// The front assembles bytes at one byte per cycle while in_ready is high
// and writes each finished field into a short queue (QUEUE_DEPTH entries);
// the back removes the length prefix and holds the result in the output
// register. Throughput is one byte per cycle while the queue is not full.
// out_valid rises once the completed field's result has passed through the
// queue into the output register. When out_ready is low the output
// register and then the queue fill; in_ready drops only once the queue is
// full and rises again in the cycle after a result leaves the full queue.
// A synchronous reset (rst_n low) clears the field in progress, empties
// the queue and drops out_valid.
`default_nettype none

module prefix_varint_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_buffer,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_decoded_value,
  output logic [3:0]       out_field_length,
  output logic             out_truncated
);

  `include "prefix_varint_decoder_assert.svh"

  logic          q_full, q_empty, q_push, q_pop, front_idle;
  pvd_pkg::rec_t q_push_data, q_pop_data;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  pvd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_push_data      (q_push_data),
    .front_idle       (front_idle)
  );

  pvd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty),
    .count     (q_count)
  );

  pvd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_data            (q_pop_data),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_decoded_value (out_decoded_value),
    .out_field_length  (out_field_length),
    .out_truncated     (out_truncated)
  );

  `PVD_ASSERT_NOW(a_trunc_zero, out_valid && out_truncated, out_decoded_value == 64'd0 && out_field_length == 4'd0)
  `PVD_ASSERT_NOW(a_len_range, out_valid && !out_truncated, out_field_length >= 4'd1 && out_field_length <= 4'd9)
  `PVD_ASSERT_NEXT(a_eob_idle, in_valid && in_ready && in_end_of_buffer, front_idle)
  `PVD_ASSERT_NOW(a_push_room, q_push, q_count != ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))

endmodule

`default_nettype wire
